// ----- rtl/grs_pkg.sv -----
package grs_pkg;

	// move queue geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QPTR_W      = QIDX_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OBST_THRESHOLD = 3'd0,
		CFG_OBST_TIMEOUT   = 3'd1,
		CFG_MIN_ON         = 3'd2,
		CFG_START_ROW      = 3'd3,
		CFG_START_COL      = 3'd4,
		CFG_START_DIR      = 3'd5
	} cfg_reg_t;

	// configuration reset values
	localparam logic [13:0] RST_OBST_THRESHOLD = 14'd150;
	localparam logic [15:0] RST_OBST_TIMEOUT   = 16'd1000;
	localparam logic [2:0]  RST_MIN_ON         = 3'd4;

	// item operations
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_PUSH  = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_ABORT = 3'd3;
	localparam logic [2:0] OP_TICK  = 3'd4;
	localparam logic [2:0] OP_PLACE = 3'd5;

	// motion requests
	localparam logic [2:0] MOT_NONE     = 3'd0;
	localparam logic [2:0] MOT_STOP     = 3'd1;
	localparam logic [2:0] MOT_FOLLOW   = 3'd2;
	localparam logic [2:0] MOT_APPROACH = 3'd3;
	localparam logic [2:0] MOT_CROSS    = 3'd4;
	localparam logic [2:0] MOT_LEFT     = 3'd5;
	localparam logic [2:0] MOT_RIGHT    = 3'd6;

	// events
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_OBSTACLE = 3'd1;
	localparam logic [2:0] EV_DONE     = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_ACCEPTED = 3'd4;

	// queued move codes
	localparam logic [1:0] MV_FWD     = 2'd0;
	localparam logic [1:0] MV_LEFT    = 2'd1;
	localparam logic [1:0] MV_RIGHT   = 2'd2;
	localparam logic [1:0] MV_UNKNOWN = 2'd3;

	// command characters
	localparam logic [7:0] CMD_NONE = 8'h00;
	localparam logic [7:0] CMD_F    = 8'h46;
	localparam logic [7:0] CMD_L    = 8'h4C;
	localparam logic [7:0] CMD_R    = 8'h52;

	// headings
	localparam logic [1:0] HD_DOWN  = 2'd0;
	localparam logic [1:0] HD_RIGHT = 2'd1;
	localparam logic [1:0] HD_UP    = 2'd2;
	localparam logic [1:0] HD_LEFT  = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  command;
		logic [4:0]  line_sensors;
		logic [13:0] obstacle_distance;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        route_state;
		logic [2:0]        motion_request;
		logic [2:0]        event_code;
		logic signed [7:0] robot_row;
		logic signed [7:0] robot_col;
		logic [1:0]        robot_heading;
		logic signed [7:0] ahead_row;
		logic signed [7:0] ahead_col;
		logic [6:0]        steps_done;
		logic [6:0]        steps_total;
		logic [6:0]        crossings;
	} out_item_t;

endpackage

// ----- rtl/grid_route_sequencer_unit.sv -----
// Route sequencer for a grid line follower. Items (queue clear, push, start, abort,
// sensor tick, place) enter on the in channel and each one yields exactly one result item
// on the out channel, showing route state, motion request, event, grid position and
// heading, the cell ahead and the step counters as they stand after that item. The unit
// takes one item per clock unless the output stalls: an item is captured in an input
// register, the whole state update is one short combinational pass, and the result lands
// in an output register when the input register drains. The one-item-per-clock figure
// is set by that single state update pass; the input stalls only while the output
// register holds an untaken result and the input register is also full. The move queue
// lives in a 64-entry memory; the entry at the queue head is fetched ahead into a register
// (with bypass of a push to the same slot), so a pop needs no read in the update pass.
// No clearing pass is needed after reset. The configuration port is always ready and
// should be written only while no item is in flight.
module grid_route_sequencer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  grs_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output grs_pkg::out_item_t               out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [grs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [grs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_FOLLOW  = 3'd1,
		MODE_CROSS   = 3'd2,
		MODE_BLOCKED = 3'd3,
		MODE_DONE    = 3'd4
	} mode_t;

	localparam logic [grs_pkg::QPTR_W-1:0] DEPTH_PTR = grs_pkg::QPTR_W'(grs_pkg::QUEUE_DEPTH);

	// one step ahead along a heading, wrapping modulo 256
	function automatic logic [15:0] step_ahead(input logic signed [7:0] r,
			input logic signed [7:0] c, input logic [1:0] hd);
		logic signed [7:0] nr;
		logic signed [7:0] nc;
		nr = r;
		nc = c;
		case (hd)
			grs_pkg::HD_DOWN:  nr = r + 8'sd1;
			grs_pkg::HD_RIGHT: nc = c + 8'sd1;
			grs_pkg::HD_UP:    nr = r - 8'sd1;
			default:           nc = c - 8'sd1;
		endcase
		return {nr, nc};
	endfunction

	// configuration registers
	logic [13:0]       obst_threshold_q;
	logic [15:0]       obst_timeout_q;
	logic [2:0]        min_on_q;
	logic signed [7:0] start_row_q;
	logic signed [7:0] start_col_q;
	logic [1:0]        start_dir_q;

	// input stage
	logic              valid_s1;
	grs_pkg::in_item_t item_s1;
	logic              advance;

	// route state
	mode_t                     mode_q, mode_d;
	logic [grs_pkg::QPTR_W-1:0] head_q, head_d;
	logic [grs_pkg::QPTR_W-1:0] tail_q, tail_d;
	logic                      was_crossing_q, was_crossing_d;
	logic                      confirm_q, confirm_d;
	logic [15:0]               blocked_q, blocked_d;
	logic signed [7:0]         row_q, row_d;
	logic signed [7:0]         col_q, col_d;
	logic [1:0]                heading_q, heading_d;
	logic [6:0]                crossings_q, crossings_d;

	// move queue memory and prefetched head entry
	logic [1:0]                move_mem [grs_pkg::QUEUE_DEPTH];
	logic [1:0]                head_entry_q;
	logic                      push_we;
	logic [1:0]                push_code;
	logic [grs_pkg::QIDX_W-1:0] wr_idx;
	logic [grs_pkg::QIDX_W-1:0] rd_idx;

	// combinational results of the update pass
	logic [2:0]        motion;
	logic [2:0]        event_c;
	logic [2:0]        on_cnt;
	logic              crossing_now;
	logic [15:0]       blocked_inc;
	logic [1:0]        turn_heading;
	logic [15:0]       moved_pos;
	logic [15:0]       ahead_pos;
	logic [grs_pkg::QPTR_W-1:0] head_inc;

	// output register
	logic               out_valid_q;
	grs_pkg::out_item_t out_item_q;

	// handshake: the input register drains whenever the output register can take a result
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obst_threshold_q <= grs_pkg::RST_OBST_THRESHOLD;
			obst_timeout_q   <= grs_pkg::RST_OBST_TIMEOUT;
			min_on_q         <= grs_pkg::RST_MIN_ON;
			start_row_q      <= '0;
			start_col_q      <= '0;
			start_dir_q      <= grs_pkg::HD_DOWN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				grs_pkg::CFG_OBST_THRESHOLD: obst_threshold_q <= cfg_data[13:0];
				grs_pkg::CFG_OBST_TIMEOUT:   obst_timeout_q   <= cfg_data;
				grs_pkg::CFG_MIN_ON:         min_on_q         <= cfg_data[2:0];
				grs_pkg::CFG_START_ROW:      start_row_q      <= cfg_data[7:0];
				grs_pkg::CFG_START_COL:      start_col_q      <= cfg_data[7:0];
				grs_pkg::CFG_START_DIR:      start_dir_q      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// sensor count against the intersection threshold
	always_comb begin
		on_cnt = '0;
		for (int i = 0; i < 5; i++) begin
			on_cnt = on_cnt + 3'(item_s1.line_sensors[i]);
		end
	end
	assign crossing_now = (on_cnt >= min_on_q);

	assign blocked_inc = (blocked_q != 16'hFFFF) ? blocked_q + 16'd1 : blocked_q;
	assign head_inc    = head_q + grs_pkg::QPTR_W'(1);

	// heading after the popped move, and the cell one step along it
	always_comb begin
		case (head_entry_q)
			grs_pkg::MV_LEFT:  turn_heading = heading_q + 2'd3;
			grs_pkg::MV_RIGHT: turn_heading = heading_q + 2'd1;
			default:           turn_heading = heading_q;
		endcase
	end
	assign moved_pos = step_ahead(row_q, col_q, turn_heading);

	// push encoding
	always_comb begin
		case (item_s1.command)
			grs_pkg::CMD_F: push_code = grs_pkg::MV_FWD;
			grs_pkg::CMD_L: push_code = grs_pkg::MV_LEFT;
			grs_pkg::CMD_R: push_code = grs_pkg::MV_RIGHT;
			default:        push_code = grs_pkg::MV_UNKNOWN;
		endcase
	end
	assign push_we = advance && (item_s1.op == grs_pkg::OP_PUSH) &&
		(item_s1.command != grs_pkg::CMD_NONE) && (tail_q < DEPTH_PTR);
	assign wr_idx  = tail_q[grs_pkg::QIDX_W-1:0];

	// the state update pass
	always_comb begin
		mode_d         = mode_q;
		head_d         = head_q;
		tail_d         = tail_q;
		was_crossing_d = was_crossing_q;
		confirm_d      = confirm_q;
		blocked_d      = blocked_q;
		row_d          = row_q;
		col_d          = col_q;
		heading_d      = heading_q;
		crossings_d    = crossings_q;
		motion         = grs_pkg::MOT_NONE;
		event_c        = grs_pkg::EV_NONE;
		case (item_s1.op)
			grs_pkg::OP_CLEAR: begin
				head_d = '0;
				tail_d = '0;
			end
			grs_pkg::OP_PUSH: begin
				if (push_we) begin
					tail_d = tail_q + grs_pkg::QPTR_W'(1);
				end
			end
			grs_pkg::OP_START: begin
				mode_d         = MODE_FOLLOW;
				crossings_d    = '0;
				was_crossing_d = 1'b0;
				confirm_d      = 1'b0;
				event_c        = grs_pkg::EV_ACCEPTED;
			end
			grs_pkg::OP_ABORT: begin
				head_d    = '0;
				tail_d    = '0;
				mode_d    = MODE_IDLE;
				confirm_d = 1'b0;
				motion    = grs_pkg::MOT_STOP;
			end
			grs_pkg::OP_PLACE: begin
				row_d     = start_row_q;
				col_d     = start_col_q;
				heading_d = start_dir_q;
			end
			grs_pkg::OP_TICK: begin
				case (mode_q)
					MODE_FOLLOW: begin
						if (confirm_q) begin
							// second look at a suspected intersection, no obstacle check
							confirm_d = 1'b0;
							if (crossing_now) begin
								mode_d         = MODE_CROSS;
								was_crossing_d = 1'b1;
								motion         = grs_pkg::MOT_APPROACH;
							end else begin
								was_crossing_d = 1'b0;
							end
						end else if (item_s1.obstacle_distance != '0 &&
								item_s1.obstacle_distance < obst_threshold_q) begin
							mode_d    = MODE_BLOCKED;
							blocked_d = '0;
							motion    = grs_pkg::MOT_STOP;
							event_c   = grs_pkg::EV_OBSTACLE;
						end else if (crossing_now && !was_crossing_q) begin
							confirm_d = 1'b1;
							motion    = grs_pkg::MOT_STOP;
						end else begin
							was_crossing_d = crossing_now;
							motion         = grs_pkg::MOT_FOLLOW;
						end
					end
					MODE_CROSS: begin
						if (head_q >= tail_q || head_q >= DEPTH_PTR) begin
							mode_d = MODE_DONE;
						end else begin
							head_d = head_inc;
							case (head_entry_q)
								grs_pkg::MV_FWD:   motion = grs_pkg::MOT_CROSS;
								grs_pkg::MV_LEFT:  motion = grs_pkg::MOT_LEFT;
								grs_pkg::MV_RIGHT: motion = grs_pkg::MOT_RIGHT;
								default:           motion = grs_pkg::MOT_NONE;
							endcase
							if (head_entry_q != grs_pkg::MV_UNKNOWN) begin
								heading_d = turn_heading;
								row_d     = moved_pos[15:8];
								col_d     = moved_pos[7:0];
							end
							crossings_d    = crossings_q + 7'd1;
							was_crossing_d = 1'b0;
							mode_d         = (head_inc >= tail_q) ? MODE_DONE : MODE_FOLLOW;
						end
					end
					MODE_BLOCKED: begin
						motion    = grs_pkg::MOT_STOP;
						blocked_d = blocked_inc;
						if (blocked_inc >= obst_timeout_q) begin
							mode_d  = MODE_IDLE;
							event_c = grs_pkg::EV_TIMEOUT;
						end
					end
					MODE_DONE: begin
						motion  = grs_pkg::MOT_STOP;
						event_c = grs_pkg::EV_DONE;
						mode_d  = MODE_IDLE;
					end
					default: begin
						motion = grs_pkg::MOT_STOP;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign ahead_pos = step_ahead(row_d, col_d, heading_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			was_crossing_q <= 1'b0;
			confirm_q      <= 1'b0;
			blocked_q      <= '0;
			row_q          <= '0;
			col_q          <= '0;
			heading_q      <= grs_pkg::HD_DOWN;
			crossings_q    <= '0;
		end else if (advance) begin
			mode_q         <= mode_d;
			head_q         <= head_d;
			tail_q         <= tail_d;
			was_crossing_q <= was_crossing_d;
			confirm_q      <= confirm_d;
			blocked_q      <= blocked_d;
			row_q          <= row_d;
			col_q          <= col_d;
			heading_q      <= heading_d;
			crossings_q    <= crossings_d;
		end
	end

	// queue memory: write at the tail, read the next head slot with write bypass
	assign rd_idx = advance ? head_d[grs_pkg::QIDX_W-1:0] : head_q[grs_pkg::QIDX_W-1:0];

	always_ff @(posedge clk) begin
		if (push_we) begin
			move_mem[wr_idx] <= push_code;
		end
		if (push_we && wr_idx == rd_idx) begin
			head_entry_q <= push_code;
		end else begin
			head_entry_q <= move_mem[rd_idx];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.route_state    <= mode_d;
			out_item_q.motion_request <= motion;
			out_item_q.event_code     <= event_c;
			out_item_q.robot_row      <= row_d;
			out_item_q.robot_col      <= col_d;
			out_item_q.robot_heading  <= heading_d;
			out_item_q.ahead_row      <= ahead_pos[15:8];
			out_item_q.ahead_col      <= ahead_pos[7:0];
			out_item_q.steps_done     <= 7'(head_d);
			out_item_q.steps_total    <= 7'(tail_d);
			out_item_q.crossings      <= crossings_d;
		end
	end

	// queue pointers stay ordered and inside the memory
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q && tail_q <= DEPTH_PTR)
		else $error("queue head passed tail or tail passed depth");

	// a held input item stays put until it can move on
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled item");

	// an obstacle result always stops the robot in the obstacle state
	a_obstacle_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.event_code == grs_pkg::EV_OBSTACLE |->
		out_item.motion_request == grs_pkg::MOT_STOP && out_item.route_state == MODE_BLOCKED)
		else $error("obstacle event without stop in obstacle state");

	// timeout and completion events both leave the route idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.event_code == grs_pkg::EV_TIMEOUT ||
		out_item.event_code == grs_pkg::EV_DONE) |-> out_item.route_state == MODE_IDLE)
		else $error("route end event while not idle");

endmodule
